### sv/kdt_pkg.sv
// Shared types and constants for the keyed device table.
// No dependencies; imported by kdt_cell and keyed_device_table_top.
`default_nettype none

package kdt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_W       = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int OP_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_UPSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // Per-cell control, issued by the top level each cycle
    typedef struct packed {
        logic cmp_en;   // register compare result against the incoming key
        logic live;     // cell lies below the fill count
        logic load;     // store the pending key
        logic shift;    // take the key of the next cell up
        logic clear;    // zero the key
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/kdt_cell.sv
// One slot of the compacting key table: key register, equality compare, shift.
// Depends on kdt_pkg.
`default_nettype none

module kdt_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire kdt_pkg::cell_ctrl_t       ctrl,
    input  wire logic [kdt_pkg::KEY_W-1:0] search_key,
    input  wire logic [kdt_pkg::KEY_W-1:0] load_key,
    input  wire logic [kdt_pkg::KEY_W-1:0] next_key,
    output logic      [kdt_pkg::KEY_W-1:0] key,
    output logic                           match
);
    import kdt_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             match_reg;
    logic             match_next;

    // Pick the next key: load, shift down from the neighbor, clear or hold
    always_comb
    begin
        priority if (ctrl.load)
        begin
            key_next = load_key;
        end
        else if (ctrl.shift)
        begin
            key_next = next_key;
        end
        else if (ctrl.clear)
        begin
            key_next = '0;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    // Compare only live slots; hold the result while the update runs
    assign match_next = ctrl.cmp_en ? (ctrl.live && (key_reg == search_key)) : match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            key_reg   <= key_next;
            match_reg <= match_next;
        end
    end

    assign key   = key_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

### sv/keyed_device_table_top.sv
// Top level of the keyed device table: row of kdt_cell slots plus sequencer.
// Depends on kdt_pkg and kdt_cell.
`default_nettype none

// Keyed device table. Holds up to 16 64-bit keys packed in insertion order.
// Raise start with operation and device_key while busy is low; the item is
// taken at that edge. Every slot compares its key against device_key at the
// accept edge; the next cycle (busy high) priority-encodes the lowest hit
// and updates the row: append on an upsert miss, shift-down on a remove
// hit. The result appears on success, slot_index and entry_count for
// exactly one cycle with done high, and cannot be stalled. An item passes
// through the compare cycle and the update cycle; a new item may be
// started in the cycle that done is shown.
module keyed_device_table_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [kdt_pkg::OP_W-1:0]    operation,
    input  wire logic [kdt_pkg::KEY_W-1:0]   device_key,
    output logic                             busy,
    output logic                             done,
    output logic                             success,
    output logic      [kdt_pkg::SLOT_W-1:0]  slot_index,
    output logic      [kdt_pkg::COUNT_W-1:0] entry_count
);
    import kdt_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t              state_reg;
    logic                done_reg;
    logic                success_reg;
    logic                success_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;

    logic                accept;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [KEY_W-1:0]    cell_key [TABLE_DEPTH];
    cell_ctrl_t          cell_ctrl [TABLE_DEPTH];
    logic                any_hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                do_append;
    logic                do_remove;

    assign accept = start && (state_reg == ST_IDLE);

    // Encode the lowest matching slot
    always_comb
    begin
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end
    assign any_hit = |match_vec;

    // Decide the operation outcome during the update cycle
    always_comb
    begin
        do_append    = 1'b0;
        do_remove    = 1'b0;
        success_next = 1'b0;
        slot_next    = '0;
        fill_next    = fill_reg;
        unique case (op_reg)
            OP_FIND:
            begin
                if (any_hit)
                begin
                    success_next = 1'b1;
                    slot_next    = SLOT_W'(hit_idx);
                end
            end
            OP_UPSERT:
            begin
                if (any_hit)
                begin
                    success_next = 1'b1;
                    slot_next    = SLOT_W'(hit_idx);
                end
                else if (fill_reg < CNT_W'(TABLE_DEPTH))
                begin
                    do_append    = 1'b1;
                    success_next = 1'b1;
                    slot_next    = SLOT_W'(fill_reg);
                    fill_next    = fill_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (any_hit)
                begin
                    do_remove    = 1'b1;
                    success_next = 1'b1;
                    fill_next    = fill_reg - CNT_W'(1);
                end
            end
            default:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    // Build the cell row; each cell hands its key to the one below
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic [KEY_W-1:0] nb_key;
        logic             in_update;

        assign in_update = (state_reg == ST_UPDATE);

        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign nb_key = '0;
        end
        else
        begin : g_mid
            assign nb_key = cell_key[g + 1];
        end

        always_comb
        begin
            cell_ctrl[g].cmp_en = accept;
            cell_ctrl[g].live   = CNT_W'(g) < fill_reg;
            cell_ctrl[g].load   = in_update && do_append && (fill_reg == CNT_W'(g));
            cell_ctrl[g].shift  = in_update && do_remove
                                  && (IDX_W'(g) >= hit_idx)
                                  && (CNT_W'(g + 1) < fill_reg);
            cell_ctrl[g].clear  = in_update && do_remove
                                  && (CNT_W'(g + 1) == fill_reg);
        end

        kdt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[g]),
            .search_key (device_key),
            .load_key   (key_reg),
            .next_key   (nb_key),
            .key        (cell_key[g]),
            .match      (match_vec[g])
        );
    end

    // Hold the pending item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= device_key;
        end
    end

    // Sequence the item and register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
            slot_reg    <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    state_reg   <= ST_IDLE;
                    done_reg    <= 1'b1;
                    success_reg <= success_next;
                    slot_reg    <= slot_next;
                    fill_reg    <= fill_next;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg == ST_UPDATE);
    assign done        = done_reg;
    assign success     = success_reg;
    assign slot_index  = slot_reg;
    assign entry_count = COUNT_W'(fill_reg);

endmodule

`default_nettype wire
